// ===== design/frame_difference_motion_mask_unit_assert.svh =====
// Assertion helpers for the motion mask unit.
// Every property is sampled on clk_i and ignored while rst_ni is low.
`ifndef FRAME_DIFFERENCE_MOTION_MASK_UNIT_ASSERT_SVH
`define FRAME_DIFFERENCE_MOTION_MASK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FDMM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FDMM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FDMM_ASSERT(label, prop, msg)
`define FDMM_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== design/fdmm_pkg.sv =====
`timescale 1ns / 1ps
package fdmm_pkg;

  // Geometry
  localparam int unsigned MaxWidthDef = 2048;
  localparam int unsigned Kernel      = 10;
  localparam int unsigned Lag         = Kernel - 1 - Kernel / 2;
  localparam int unsigned HistW       = Kernel - 1;
  localparam int unsigned MemW        = HistW + Lag;

  // Field widths
  localparam int unsigned PosW     = 12;
  localparam int unsigned OutPosW  = 11;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned WeightW  = 4;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned StepW    = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned ProdW    = WeightW + ChanW;
  localparam int unsigned WsumW    = WeightW + 2;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned ChunkW   = 4;
  localparam int unsigned MaxStep  = 16;

  // Register reset values
  localparam logic [WeightW-1:0]  WeightHueRst = 4'd4;
  localparam logic [WeightW-1:0]  WeightSatRst = 4'd4;
  localparam logic [WeightW-1:0]  WeightValRst = 4'd2;
  localparam logic [ThrW-1:0]     ThresholdRst = 8'd30;
  localparam logic [StepW-1:0]    StepRst      = 5'd5;
  localparam logic [PosW-1:0]     WidthRst     = 12'd1280;
  localparam logic [PosW-1:0]     HeightRst    = 12'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WEIGHT_HUE   = 3'd0,
    CFG_WEIGHT_SAT   = 3'd1,
    CFG_WEIGHT_VAL   = 3'd2,
    CFG_THRESHOLD    = 3'd3,
    CFG_SAMPLE_STEP  = 3'd4,
    CFG_FRAME_WIDTH  = 3'd5,
    CFG_FRAME_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [WeightW-1:0] weight_hue;
    logic [WeightW-1:0] weight_sat;
    logic [WeightW-1:0] weight_val;
    logic [ThrW-1:0]    diff_threshold;
    logic [StepW-1:0]   sample_step;
    logic [PosW-1:0]    frame_width;
    logic [PosW-1:0]    frame_height;
  } cfg_t;

  // Classified pixel handed from the front end to the back end
  typedef struct packed {
    logic [PosW-1:0]    pos_x;
    logic               is_real;
    logic               raw;
    logic               prior;
    logic               top;
    logic               row_start;
    logic               emit;
    logic [OutPosW-1:0] out_x;
    logic [OutPosW-1:0] out_y;
  } item_t;

endpackage

// ===== design/fdmm_pix_if.sv =====
`timescale 1ns / 1ps
interface fdmm_pix_if;
  import fdmm_pkg::*;

  logic               valid;
  logic               ready;
  logic [PosW-1:0]    pos_x;
  logic [PosW-1:0]    pos_y;
  logic [ChanW-1:0]   cur_hue;
  logic [ChanW-1:0]   cur_sat;
  logic [ChanW-1:0]   cur_val;
  logic [ChanW-1:0]   old_hue;
  logic [ChanW-1:0]   old_sat;
  logic [ChanW-1:0]   old_val;
  logic               permitted;
  logic               prior_mark;

  modport source (
    output valid, pos_x, pos_y, cur_hue, cur_sat, cur_val, old_hue, old_sat, old_val,
           permitted, prior_mark,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, cur_hue, cur_sat, cur_val, old_hue, old_sat, old_val,
           permitted, prior_mark,
    output ready
  );
endinterface

// ===== design/fdmm_mask_if.sv =====
`timescale 1ns / 1ps
interface fdmm_mask_if;
  import fdmm_pkg::*;

  logic               valid;
  logic               ready;
  logic [OutPosW-1:0] out_x;
  logic [OutPosW-1:0] out_y;
  logic               moved;

  modport source (output valid, out_x, out_y, moved, input ready);
  modport sink (input valid, out_x, out_y, moved, output ready);
endinterface

// ===== design/fdmm_cfg_if.sv =====
`timescale 1ns / 1ps
interface fdmm_cfg_if;
  import fdmm_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/frame_difference_motion_mask_unit.sv =====
// Throughput: one pixel word per cycle, sustained, while the output side keeps up.
// The result word caused by a pixel passes two front stages, the queue, the history
// read and the output register after the pixel is accepted.
// Reset: control state clears at once; the column history memory is then swept to
// zero across all MAX_WIDTH addresses, during which no pixel word is accepted.
`timescale 1ns / 1ps
`include "frame_difference_motion_mask_unit_assert.svh"
module frame_difference_motion_mask_unit #(
  parameter int unsigned MAX_WIDTH = fdmm_pkg::MaxWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fdmm_cfg_if.sink     cfg_i,
  fdmm_pix_if.sink     pix_i,
  fdmm_mask_if.source  mask_o
);
  import fdmm_pkg::*;

  cfg_t  cfg_q;
  logic  clr_busy;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight_hue     <= WeightHueRst;
      cfg_q.weight_sat     <= WeightSatRst;
      cfg_q.weight_val     <= WeightValRst;
      cfg_q.diff_threshold <= ThresholdRst;
      cfg_q.sample_step    <= StepRst;
      cfg_q.frame_width    <= WidthRst;
      cfg_q.frame_height   <= HeightRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_WEIGHT_HUE:   cfg_q.weight_hue     <= cfg_i.data[WeightW-1:0];
        CFG_WEIGHT_SAT:   cfg_q.weight_sat     <= cfg_i.data[WeightW-1:0];
        CFG_WEIGHT_VAL:   cfg_q.weight_val     <= cfg_i.data[WeightW-1:0];
        CFG_THRESHOLD:    cfg_q.diff_threshold <= cfg_i.data[ThrW-1:0];
        CFG_SAMPLE_STEP:  cfg_q.sample_step    <= cfg_i.data[StepW-1:0];
        CFG_FRAME_WIDTH:  cfg_q.frame_width    <= cfg_i.data[PosW-1:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height   <= cfg_i.data[PosW-1:0];
        default: ;
      endcase
    end
  end

  fdmm_front #(.MaxWidth(MAX_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .hold_i       (clr_busy),
    .pix_i        (pix_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  fdmm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  fdmm_back #(.MaxWidth(MAX_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .clr_busy_o  (clr_busy),
    .mask_o      (mask_o)
  );

  `FDMM_ASSERT_NEVER(a_no_accept_in_clear, clr_busy && pix_i.ready, "pixel taken during clear")
  `FDMM_ASSERT_NEVER(a_no_pop_in_clear, clr_busy && pop_valid && pop_ready, "queue popped during clear")
  `FDMM_ASSERT_NEVER(a_no_result_in_clear, clr_busy && mask_o.valid, "result shown during clear")
  `FDMM_ASSERT(a_stalled_push_holds, push_valid && !push_ready |=> push_valid, "front dropped a word")

endmodule

// ===== design/fdmm_front.sv =====
`timescale 1ns / 1ps
module fdmm_front #(
  parameter int unsigned MaxWidth = fdmm_pkg::MaxWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fdmm_pkg::cfg_t  cfg_i,
  input  logic            hold_i,
  fdmm_pix_if.sink        pix_i,
  output logic            push_valid_o,
  output fdmm_pkg::item_t push_item_o,
  input  logic            push_ready_i
);
  import fdmm_pkg::*;

  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Four restoring remainder steps, one input bit each
  function automatic logic [StepW-1:0] rem_chunk(input logic [StepW-1:0] rem,
                                                 input logic [ChunkW-1:0] bits,
                                                 input logic [StepW-1:0] divisor);
    logic [StepW-1:0] acc;
    acc = rem;
    for (int i = ChunkW - 1; i >= 0; i--) begin
      acc = {acc[StepW-2:0], bits[i]};
      if (acc >= divisor) acc = acc - divisor;
    end
    return acc;
  endfunction

  logic               advance;
  logic [StepW-1:0]   step;
  logic [WsumW-1:0]   wsum;

  // Stage 1: channel differences, top remainder chunk
  logic               s1_valid_q;
  logic [PosW-1:0]    s1_px_q, s1_py_q;
  logic [ChanW-1:0]   s1_dh_q, s1_ds_q, s1_dv_q;
  logic [StepW-1:0]   s1_rx_q, s1_ry_q;
  logic               s1_permit_q, s1_prior_q;

  // Stage 2: weighted terms, middle remainder chunk
  logic               s2_valid_q;
  logic [PosW-1:0]    s2_px_q, s2_py_q;
  logic [ProdW-1:0]   s2_ph_q, s2_ps_q, s2_pv_q;
  logic [SumW-1:0]    s2_thr_q;
  logic               s2_wnz_q;
  logic [StepW-1:0]   s2_rx_q, s2_ry_q;
  logic               s2_permit_q, s2_prior_q;

  // Clamp grid spacing into 1..MaxStep
  always_comb begin
    if (cfg_i.sample_step == '0) begin
      step = StepW'(1);
    end else if (cfg_i.sample_step > StepW'(MaxStep)) begin
      step = StepW'(MaxStep);
    end else begin
      step = cfg_i.sample_step;
    end
  end

  assign wsum = WsumW'(cfg_i.weight_hue) + WsumW'(cfg_i.weight_sat)
              + WsumW'(cfg_i.weight_val);

  assign advance     = !s2_valid_q || push_ready_i;
  assign pix_i.ready = advance && !hold_i;

  // Advance the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= pix_i.valid && !hold_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_px_q     <= pix_i.pos_x;
      s1_py_q     <= pix_i.pos_y;
      s1_dh_q     <= abs_diff(pix_i.cur_hue, pix_i.old_hue);
      s1_ds_q     <= abs_diff(pix_i.cur_sat, pix_i.old_sat);
      s1_dv_q     <= abs_diff(pix_i.cur_val, pix_i.old_val);
      s1_rx_q     <= rem_chunk('0, pix_i.pos_x[PosW-1 -: ChunkW], step);
      s1_ry_q     <= rem_chunk('0, pix_i.pos_y[PosW-1 -: ChunkW], step);
      s1_permit_q <= pix_i.permitted;
      s1_prior_q  <= pix_i.prior_mark;

      s2_px_q     <= s1_px_q;
      s2_py_q     <= s1_py_q;
      s2_ph_q     <= ProdW'(cfg_i.weight_hue) * ProdW'(s1_dh_q);
      s2_ps_q     <= ProdW'(cfg_i.weight_sat) * ProdW'(s1_ds_q);
      s2_pv_q     <= ProdW'(cfg_i.weight_val) * ProdW'(s1_dv_q);
      s2_thr_q    <= SumW'(cfg_i.diff_threshold) * SumW'(wsum);
      s2_wnz_q    <= (wsum != '0);
      s2_rx_q     <= rem_chunk(s1_rx_q, s1_px_q[PosW-ChunkW-1 -: ChunkW], step);
      s2_ry_q     <= rem_chunk(s1_ry_q, s1_py_q[PosW-ChunkW-1 -: ChunkW], step);
      s2_permit_q <= s1_permit_q;
      s2_prior_q  <= s1_prior_q;
    end
  end

  // Classify: grid hit, threshold test, real pixel, emission window
  logic [SumW-1:0]  sum;
  logic             on_grid, hit, is_real, emit;
  logic [PosW-1:0]  px_lag, py_lag;

  always_comb begin
    sum     = SumW'(s2_ph_q) + SumW'(s2_ps_q) + SumW'(s2_pv_q);
    hit     = s2_wnz_q && (sum >= s2_thr_q);
    on_grid = (rem_chunk(s2_rx_q, s2_px_q[ChunkW-1:0], step) == '0)
           && (rem_chunk(s2_ry_q, s2_py_q[ChunkW-1:0], step) == '0);
    is_real = (s2_px_q < cfg_i.frame_width)
           && ({1'b0, s2_px_q} < (PosW + 1)'(MaxWidth))
           && (s2_py_q < cfg_i.frame_height);
    px_lag  = s2_px_q - PosW'(Lag);
    py_lag  = s2_py_q - PosW'(Lag);
    emit    = (s2_px_q >= PosW'(Lag)) && (s2_py_q >= PosW'(Lag))
           && (px_lag < cfg_i.frame_width) && (py_lag < cfg_i.frame_height);

    push_item_o.pos_x     = s2_px_q;
    push_item_o.is_real   = is_real;
    push_item_o.raw       = is_real && on_grid && s2_permit_q && !s2_prior_q && hit;
    push_item_o.prior     = s2_prior_q;
    push_item_o.top       = (s2_py_q == '0);
    push_item_o.row_start = (s2_px_q == '0);
    push_item_o.emit      = emit;
    push_item_o.out_x     = px_lag[OutPosW-1:0];
    push_item_o.out_y     = py_lag[OutPosW-1:0];
  end

  assign push_valid_o = s2_valid_q;

endmodule

// ===== design/fdmm_queue.sv =====
`timescale 1ns / 1ps
module fdmm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  fdmm_pkg::item_t push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output fdmm_pkg::item_t pop_item_o,
  input  logic            pop_ready_i
);
  import fdmm_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  item_t           slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != (PtrW + 1)'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push) slots_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// ===== design/fdmm_back.sv =====
`timescale 1ns / 1ps
module fdmm_back #(
  parameter int unsigned MaxWidth = fdmm_pkg::MaxWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  input  fdmm_pkg::item_t pop_item_i,
  output logic            pop_ready_o,
  output logic            clr_busy_o,
  fdmm_mask_if.source     mask_o
);
  import fdmm_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxWidth);

  logic [MemW-1:0]  mem_q [MaxWidth];
  logic [MemW-1:0]  rd_q;
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  logic             a_valid_q;
  item_t            a_item_q;
  logic             fire, pop;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [MemW-1:0]  wdata;

  logic [HistW-1:0] win_q, win_d, win, oldd, newd;
  logic [Lag-1:0]   dly_q, dly_d, dly, oldp, newp;
  logic             col_or, pr, dil, pc;

  logic             out_valid_q;
  logic [OutPosW-1:0] out_x_q, out_y_q;
  logic             moved_q;

  assign fire        = a_valid_q && (!out_valid_q || mask_o.ready);
  assign pop_ready_o = !clr_busy_q && (!a_valid_q || fire);
  assign pop         = pop_valid_i && pop_ready_o;
  assign clr_busy_o  = clr_busy_q;

  // Sweep the column histories to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AddrW'(MaxWidth - 1)) clr_busy_q <= 1'b0;
    end
  end

  // Update histories, dilation window and prior-mark delay for the item in flight
  always_comb begin
    oldd = a_item_q.top ? '0 : rd_q[MemW-1:Lag];
    oldp = a_item_q.top ? '0 : rd_q[Lag-1:0];
    newd = {oldd[HistW-2:0], a_item_q.raw};
    newp = {oldp[Lag-2:0], a_item_q.prior};
    if (a_item_q.is_real) begin
      col_or = a_item_q.raw || (oldd != '0);
      pr     = oldp[Lag-1];
    end else begin
      col_or = 1'b0;
      pr     = 1'b0;
    end
    win   = a_item_q.row_start ? '0 : win_q;
    dil   = col_or || (win != '0);
    win_d = {win[HistW-2:0], col_or};
    dly   = a_item_q.row_start ? '0 : dly_q;
    pc    = dly[Lag-1];
    dly_d = {dly[Lag-2:0], pr};
  end

  // Select the write: clearing sweep or history write-back
  always_comb begin
    raddr = pop_item_i.pos_x[AddrW-1:0];
    if (clr_busy_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else begin
      we    = fire && a_item_q.is_real;
      waddr = a_item_q.pos_x[AddrW-1:0];
      wdata = {newd, newp};
    end
  end

  // Column history memory, read forwarded from a same-cycle write
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (pop) begin
      if (we && (waddr == raddr)) begin
        rd_q <= wdata;
      end else begin
        rd_q <= mem_q[raddr];
      end
    end
  end

  // Hold the item in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
      dly_q       <= '0;
    end else begin
      if (pop) begin
        a_valid_q <= 1'b1;
      end else if (fire) begin
        a_valid_q <= 1'b0;
      end
      if (fire) begin
        win_q <= win_d;
        dly_q <= dly_d;
      end
      if (fire && a_item_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (mask_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) a_item_q <= pop_item_i;
    if (fire && a_item_q.emit) begin
      out_x_q <= a_item_q.out_x;
      out_y_q <= a_item_q.out_y;
      moved_q <= dil || pc;
    end
  end

  assign mask_o.valid = out_valid_q;
  assign mask_o.out_x = out_x_q;
  assign mask_o.out_y = out_y_q;
  assign mask_o.moved = moved_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import fdmm_pkg::*;

  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxPos = 2051;

  typedef struct {
    logic [PosW-1:0]  x;
    logic [PosW-1:0]  y;
    logic [ChanW-1:0] cur_h;
    logic [ChanW-1:0] cur_s;
    logic [ChanW-1:0] cur_v;
    logic [ChanW-1:0] old_h;
    logic [ChanW-1:0] old_s;
    logic [ChanW-1:0] old_v;
    logic             permit;
    logic             prior;
  } pixel_t;

  typedef struct {
    logic [OutPosW-1:0] x;
    logic [OutPosW-1:0] y;
    logic               moved;
  } mask_word_t;

  // Track the motion mask the block should produce, one pixel word at a time
  class motion_mask_board;
    logic [WeightW-1:0] w_hue, w_sat, w_val;
    logic [ThrW-1:0]    threshold;
    logic [StepW-1:0]   step_reg;
    logic [PosW-1:0]    width, height;
    logic [HistW-1:0]   diff_hist [MaxWidthDef];
    logic [Lag-1:0]     prior_hist [MaxWidthDef];
    logic [HistW-1:0]   win_cols;
    logic [Lag-1:0]     prior_dly;
    mask_word_t         pending_masks [$];
    int unsigned        pixels_seen, masks_checked, marks_seen, mismatches;

    function new();
      foreach (diff_hist[i]) begin
        diff_hist[i] = '0;
        prior_hist[i] = '0;
      end
      win_cols = '0;
      prior_dly = '0;
      w_hue = WeightHueRst;
      w_sat = WeightSatRst;
      w_val = WeightValRst;
      threshold = ThresholdRst;
      step_reg = StepRst;
      width = WidthRst;
      height = HeightRst;
      pixels_seen = 0;
      masks_checked = 0;
      marks_seen = 0;
      mismatches = 0;
    endfunction

    function void note_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_WEIGHT_HUE:   w_hue = data[WeightW-1:0];
        CFG_WEIGHT_SAT:   w_sat = data[WeightW-1:0];
        CFG_WEIGHT_VAL:   w_val = data[WeightW-1:0];
        CFG_THRESHOLD:    threshold = data[ThrW-1:0];
        CFG_SAMPLE_STEP:  step_reg = data[StepW-1:0];
        CFG_FRAME_WIDTH:  width = data[PosW-1:0];
        CFG_FRAME_HEIGHT: height = data[PosW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned chan_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    // Classify, update the row and column histories, queue the delayed mask word
    function void take_pixel(pixel_t p);
      int unsigned px, py, grid, wsum, sum;
      logic is_real, raw, col_or, delayed, dil, out_prior;
      logic [HistW-1:0] old_diff, win;
      logic [Lag-1:0] old_prior, dly;
      mask_word_t m;
      px = p.x;
      py = p.y;
      raw = 1'b0;
      col_or = 1'b0;
      delayed = 1'b0;
      grid = (step_reg == 0) ? 1 : ((step_reg > MaxStep) ? MaxStep : step_reg);
      is_real = px < width && px < MaxWidthDef && py < height;
      if (is_real && px % grid == 0 && py % grid == 0 && p.permit && !p.prior) begin
        wsum = w_hue + w_sat + w_val;
        sum = w_hue * chan_diff(p.cur_h, p.old_h) + w_sat * chan_diff(p.cur_s, p.old_s)
            + w_val * chan_diff(p.cur_v, p.old_v);
        raw = (wsum != 0) && (sum >= threshold * wsum);
      end
      // Padding neither reads nor writes the column stores
      if (is_real) begin
        old_diff = (py == 0) ? '0 : diff_hist[px];
        old_prior = (py == 0) ? '0 : prior_hist[px];
        col_or = raw | (|old_diff);
        diff_hist[px] = {old_diff[HistW-2:0], raw};
        delayed = old_prior[Lag-1];
        prior_hist[px] = {old_prior[Lag-2:0], p.prior};
      end
      win = (px == 0) ? '0 : win_cols;
      dil = col_or | (|win);
      win_cols = {win[HistW-2:0], col_or};
      dly = (px == 0) ? '0 : prior_dly;
      out_prior = dly[Lag-1];
      prior_dly = {dly[Lag-2:0], delayed};
      pixels_seen++;
      if (px >= Lag && py >= Lag && px - Lag < width && py - Lag < height) begin
        m.x = px - Lag;
        m.y = py - Lag;
        m.moved = dil | out_prior;
        pending_masks.push_back(m);
      end
    endfunction

    function void check_mask(logic [OutPosW-1:0] x, logic [OutPosW-1:0] y, logic moved);
      mask_word_t want;
      if (pending_masks.size() == 0) begin
        note_error($sformatf("unexpected mask word x=%0d y=%0d moved=%0b", x, y, moved));
        return;
      end
      want = pending_masks.pop_front();
      masks_checked++;
      if (want.moved) marks_seen++;
      if (want.x !== x || want.y !== y || want.moved !== moved)
        note_error($sformatf("mask word mismatch: expected x=%0d y=%0d moved=%0b, got x=%0d y=%0d moved=%0b",
                             want.x, want.y, want.moved, x, y, moved));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  fdmm_cfg_if  cfg ();
  fdmm_pix_if  pix ();
  fdmm_mask_if mask ();

  frame_difference_motion_mask_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix),
    .mask_o (mask)
  );

  motion_mask_board board;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_left = 0;
  int unsigned settings_used = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
  end

  // Stall the mask side at random, or hold it off for a requested stretch
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      mask.ready <= 1'b0;
    end else begin
      mask.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Observe every handshake on the three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) board.write_reg(cfg_idx_e'(cfg.index), cfg.data);
      if (pix.valid && pix.ready) begin
        board.take_pixel('{pix.pos_x, pix.pos_y, pix.cur_hue, pix.cur_sat, pix.cur_val,
                           pix.old_hue, pix.old_sat, pix.old_val, pix.permitted,
                           pix.prior_mark});
      end
      if (mask.valid && mask.ready) board.check_mask(mask.out_x, mask.out_y, mask.moved);
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic cfg_t make_cfg(int unsigned wh, int unsigned ws, int unsigned wv,
                                    int unsigned thr, int unsigned step,
                                    int unsigned w, int unsigned h);
    cfg_t c;
    c.weight_hue = wh;
    c.weight_sat = ws;
    c.weight_val = wv;
    c.diff_threshold = thr;
    c.sample_step = step;
    c.frame_width = w;
    c.frame_height = h;
    return c;
  endfunction

  function automatic pixel_t pixel_of(int unsigned x, int unsigned y, logic [ChanW-1:0] cur,
                                      logic [ChanW-1:0] old, logic permit, logic prior);
    pixel_t p;
    p.x = x;
    p.y = y;
    p.cur_h = cur;
    p.cur_s = cur;
    p.cur_v = cur;
    p.old_h = old;
    p.old_s = old;
    p.old_v = old;
    p.permit = permit;
    p.prior = prior;
    return p;
  endfunction

  // Mix near-identical and unrelated pixel pairs so both outcomes show up
  function automatic pixel_t random_pixel(int unsigned x, int unsigned y);
    pixel_t p;
    p = pixel_of(x, y, $urandom, $urandom, $urandom_range(99) < 90, $urandom_range(99) < 6);
    p.cur_s = $urandom;
    p.cur_v = $urandom;
    if ($urandom_range(1)) begin
      p.old_h = p.cur_h + $urandom_range(15);
      p.old_s = p.cur_s - $urandom_range(15);
      p.old_v = p.cur_v + $urandom_range(15);
    end else begin
      p.old_s = $urandom;
      p.old_v = $urandom;
    end
    return p;
  endfunction

  task automatic put_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk_i); while (!cfg.ready);
  endtask

  task automatic apply_settings(cfg_t c);
    put_reg(CFG_WEIGHT_HUE, c.weight_hue);
    put_reg(CFG_WEIGHT_SAT, c.weight_sat);
    put_reg(CFG_WEIGHT_VAL, c.weight_val);
    put_reg(CFG_THRESHOLD, c.diff_threshold);
    put_reg(CFG_SAMPLE_STEP, c.sample_step);
    put_reg(CFG_FRAME_WIDTH, c.frame_width);
    put_reg(CFG_FRAME_HEIGHT, c.frame_height);
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic idle_mix(int unsigned send_pct, int unsigned recv_pct);
    send_gap_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < send_gap_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pos_x <= p.x;
    pix.pos_y <= p.y;
    pix.cur_hue <= p.cur_h;
    pix.cur_sat <= p.cur_s;
    pix.cur_val <= p.cur_v;
    pix.old_hue <= p.old_h;
    pix.old_sat <= p.old_s;
    pix.old_val <= p.old_v;
    pix.permitted <= p.permit;
    pix.prior_mark <= p.prior;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  // Drop valid, drain all mask words, then let the pipeline go quiet
  task automatic settle();
    pix.valid <= 1'b0;
    while (board.pending_masks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Send one padded frame in raster order
  task automatic run_frame(int unsigned w, int unsigned h);
    for (int unsigned y = 0; y < h + Lag; y++)
      for (int unsigned x = 0; x < w + Lag; x++)
        send_pixel(random_pixel(x, y));
  endtask

  // Scatter pixels at random positions, mostly near the frame
  task automatic run_noise(int unsigned count, int unsigned w, int unsigned h);
    int unsigned x, y;
    repeat (count) begin
      x = ($urandom_range(3) != 0) ? $urandom_range(w + Lag - 1) : $urandom_range(MaxPos);
      y = ($urandom_range(3) != 0) ? $urandom_range(h + Lag - 1) : $urandom_range(MaxPos);
      send_pixel(random_pixel(x, y));
    end
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_WEIGHT_HUE;
    cfg.data = '0;
    pix.valid = 1'b0;
    pix.pos_x = '0;
    pix.pos_y = '0;
    pix.cur_hue = '0;
    pix.cur_sat = '0;
    pix.cur_val = '0;
    pix.old_hue = '0;
    pix.old_sat = '0;
    pix.old_val = '0;
    pix.permitted = 1'b0;
    pix.prior_mark = 1'b0;
    mask.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full weights and top threshold: only a full-scale difference marks
    idle_mix(0, 0);
    apply_settings(make_cfg(15, 15, 15, 255, 1, 6, 5));
    send_pixel(pixel_of(0, 0, 255, 0, 1, 0));
    send_pixel(pixel_of(1, 0, 254, 0, 1, 0));
    send_pixel(pixel_of(2, 0, 0, 255, 1, 1));
    send_pixel(pixel_of(3, 0, 255, 0, 0, 0));
    send_pixel(pixel_of(4, 4, 0, 255, 1, 0));
    send_pixel(pixel_of(5, 4, 0, 0, 1, 0));
    send_pixel(pixel_of(6, 4, 255, 0, 1, 1));
    send_pixel(pixel_of(9, 4, 0, 0, 1, 0));
    send_pixel(pixel_of(0, 5, 255, 0, 1, 0));
    send_pixel(pixel_of(4, 5, 0, 0, 1, 0));
    send_pixel(pixel_of(9, 8, 0, 0, 1, 0));
    send_pixel(pixel_of(10, 8, 255, 0, 1, 0));
    send_pixel(pixel_of(2047, 2047, 255, 0, 1, 1));
    send_pixel(pixel_of(2048, 3, 255, 0, 1, 0));
    send_pixel(pixel_of(MaxPos, MaxPos, 255, 0, 1, 1));
    settle();

    // Zero weight sum never marks, even with a zero threshold
    apply_settings(make_cfg(0, 0, 0, 0, 16, 6, 5));
    send_pixel(pixel_of(0, 0, 255, 0, 1, 0));
    send_pixel(pixel_of(4, 4, 255, 0, 1, 0));
    send_pixel(pixel_of(5, 5, 0, 0, 1, 0));
    send_pixel(pixel_of(9, 8, 0, 255, 1, 0));
    settle();

    apply_settings(make_cfg(4, 4, 2, 30, 1, 16, 12));
    run_frame(16, 12);
    run_frame(16, 12);
    settle();

    apply_settings(make_cfg($urandom_range(15), $urandom_range(15), $urandom_range(15),
                            60, 3, 20, 10));
    idle_mix(57, 0);
    run_frame(20, 10);
    settle();

    // Step of zero behaves as one
    apply_settings(make_cfg($urandom_range(1, 15), $urandom_range(15), $urandom_range(15),
                            0, 0, 12, 14));
    idle_mix(0, 57);
    run_frame(12, 14);
    settle();

    // Step above the grid limit behaves as the limit
    apply_settings(make_cfg($urandom_range(15), $urandom_range(15), $urandom_range(15),
                            100, 31, 9, 9));
    idle_mix(9, 9);
    run_frame(9, 9);
    settle();

    // Narrowest and tallest frame, then widest and shortest
    apply_settings(make_cfg($urandom_range(15), $urandom_range(15), 15, 50, 2, 1, 2048));
    idle_mix(0, 0);
    run_frame(1, 2048);
    settle();

    apply_settings(make_cfg(15, $urandom_range(15), $urandom_range(15), 50, 7, 2048, 1));
    idle_mix(0, 57);
    run_frame(2048, 1);
    settle();

    // Hold the mask side off while pixels keep coming, so the input backs up
    apply_settings(make_cfg($urandom_range(15), $urandom_range(15), $urandom_range(15),
                            40, 2, 32, 8));
    idle_mix(0, 0);
    holdoff_left = 300;
    run_frame(32, 8);
    settle();

    apply_settings(make_cfg($urandom_range(15), $urandom_range(15), $urandom_range(15),
                            45, 4, 24, 16));
    idle_mix(9, 9);
    run_noise(400, 24, 16);
    settle();

    apply_settings(make_cfg($urandom_range(15), $urandom_range(15), $urandom_range(15),
                            35, 1, 40, 20));
    idle_mix(57, 0);
    run_frame(40, 20);
    settle();

    if (board.pending_masks.size() != 0)
      board.note_error($sformatf("%0d mask words never arrived", board.pending_masks.size()));
    $display("covered %0d pixel words under %0d register settings", board.pixels_seen,
             settings_used);
    $display("checked %0d mask words, %0d of them marked, %0d mismatches", board.masks_checked,
             board.marks_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
